// ===== src/rft_pkg.sv =====
// Shared types and constants of the radial falloff texel pipeline.
// Used by every module under src; depends on nothing else.
package rft_pkg;

    // Width and reset value of the map size register
    localparam int              CFG_W          = 13;
    localparam logic [CFG_W-1:0] MAP_SIZE_RESET = 13'd64;

    // Width and full-scale value of the result byte
    localparam int           OUT_W   = 8;
    localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;

    // Dependent steps folded into one stage of the divider and the root unit
    localparam int DIV_STEPS  = 4;
    localparam int SQRT_STEPS = 4;

    // Control that travels alongside each word
    typedef struct packed {
        logic valid;
        logic clamp;
    } t_ctrl;

endpackage

// ===== src/rft_div.sv =====
// Pipelined restoring divider: quotient num * 2^(2*FRAC_BITS) / den.
// Needs rft_pkg for the stage depth and the control struct.
module rft_div import rft_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int DEN_W     = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl                  i_ctrl,
    input  logic [DEN_W-1:0]       i_num,
    input  logic [DEN_W-1:0]       i_den,
    output t_ctrl                  o_ctrl,
    output logic [2*FRAC_BITS-1:0] o_quo
);

    localparam int Q_W  = 2 * FRAC_BITS;
    localparam int N_ST = (Q_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int ST_W = DEN_W + Q_W;

    // Run up to DIV_STEPS quotient bits; packs {remainder, quotient}
    function automatic logic [ST_W-1:0] f_stage(
        input logic [DEN_W-1:0] rem_in,
        input logic [Q_W-1:0]   quo_in,
        input logic [DEN_W-1:0] den,
        input int               base
    );
        logic [DEN_W:0] rem_v;
        logic [Q_W-1:0] quo_v;
        rem_v = {1'b0, rem_in};
        quo_v = quo_in;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (base + j < Q_W) begin
                rem_v = {rem_v[DEN_W-1:0], 1'b0};
                quo_v = {quo_v[Q_W-2:0], 1'b0};
                if (rem_v >= {1'b0, den}) begin
                    rem_v    = rem_v - {1'b0, den};
                    quo_v[0] = 1'b1;
                end
            end
        end
        return {rem_v[DEN_W-1:0], quo_v};
    endfunction

    t_ctrl            r_ctrl   [N_ST];
    logic [Q_W-1:0]   r_quo    [N_ST];
    logic [DEN_W-1:0] r_rem    [N_ST-1];
    t_ctrl            w_ctrl_in[N_ST];
    logic [Q_W-1:0]   w_quo_in [N_ST];
    logic [DEN_W-1:0] w_rem_in [N_ST];
    logic [ST_W-1:0]  w_step   [N_ST];

    for (genvar g = 0; g < N_ST; g++) begin : g_stage
        // Take the word from the port or from the stage before
        if (g == 0) begin : g_head
            assign w_ctrl_in[g] = i_ctrl;
            assign w_rem_in[g]  = i_num;
            assign w_quo_in[g]  = '0;
        end else begin : g_body
            assign w_ctrl_in[g] = r_ctrl[g-1];
            assign w_rem_in[g]  = r_rem[g-1];
            assign w_quo_in[g]  = r_quo[g-1];
        end

        assign w_step[g] = f_stage(w_rem_in[g], w_quo_in[g], i_den, g * DIV_STEPS);

        // Advance control and quotient
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[g] <= '0;
            end else begin
                r_ctrl[g] <= w_ctrl_in[g];
            end
            r_quo[g] <= w_step[g][Q_W-1:0];
        end

        // Hold the partial remainder for the next stage
        if (g < N_ST - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[g] <= w_step[g][ST_W-1:Q_W];
            end
        end
    end

    assign o_ctrl = r_ctrl[N_ST-1];
    assign o_quo  = r_quo[N_ST-1];

endmodule

// ===== src/rft_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per step.
// Needs rft_pkg for the stage depth and the control struct.
module rft_sqrt import rft_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl                  i_ctrl,
    input  logic [2*FRAC_BITS-1:0] i_rad,
    output t_ctrl                  o_ctrl,
    output logic [FRAC_BITS-1:0]   o_root
);

    localparam int F    = FRAC_BITS;
    localparam int N_ST = (F + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int ST_W = 4 * F;

    // Run up to SQRT_STEPS root bits; packs {remainder, root, radicand left}
    function automatic logic [ST_W-1:0] f_stage(
        input logic [F-1:0]   rem_in,
        input logic [F-1:0]   root_in,
        input logic [2*F-1:0] rad_in,
        input int             base
    );
        logic [F+1:0]   rem_v;
        logic [F+1:0]   trial;
        logic [F-1:0]   root_v;
        logic [2*F-1:0] rad_v;
        rem_v  = {2'b00, rem_in};
        root_v = root_in;
        rad_v  = rad_in;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            if (base + j < F) begin
                rem_v = {rem_v[F-1:0], rad_v[2*F-1:2*F-2]};
                rad_v = {rad_v[2*F-3:0], 2'b00};
                trial = {root_v, 2'b01};
                if (rem_v >= trial) begin
                    rem_v  = rem_v - trial;
                    root_v = {root_v[F-2:0], 1'b1};
                end else begin
                    root_v = {root_v[F-2:0], 1'b0};
                end
            end
        end
        return {rem_v[F-1:0], root_v, rad_v};
    endfunction

    t_ctrl          r_ctrl    [N_ST];
    logic [F-1:0]   r_root    [N_ST];
    logic [F-1:0]   r_rem     [N_ST-1];
    logic [2*F-1:0] r_rad     [N_ST-1];
    t_ctrl          w_ctrl_in [N_ST];
    logic [F-1:0]   w_rem_in  [N_ST];
    logic [F-1:0]   w_root_in [N_ST];
    logic [2*F-1:0] w_rad_in  [N_ST];
    logic [ST_W-1:0] w_step   [N_ST];

    for (genvar g = 0; g < N_ST; g++) begin : g_stage
        // Take the word from the port or from the stage before
        if (g == 0) begin : g_head
            assign w_ctrl_in[g] = i_ctrl;
            assign w_rem_in[g]  = '0;
            assign w_root_in[g] = '0;
            assign w_rad_in[g]  = i_rad;
        end else begin : g_body
            assign w_ctrl_in[g] = r_ctrl[g-1];
            assign w_rem_in[g]  = r_rem[g-1];
            assign w_root_in[g] = r_root[g-1];
            assign w_rad_in[g]  = r_rad[g-1];
        end

        assign w_step[g] = f_stage(w_rem_in[g], w_root_in[g], w_rad_in[g], g * SQRT_STEPS);

        // Advance control and partial root
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[g] <= '0;
            end else begin
                r_ctrl[g] <= w_ctrl_in[g];
            end
            r_root[g] <= w_step[g][3*F-1:2*F];
        end

        // Hold remainder and unused radicand bits for the next stage
        if (g < N_ST - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[g] <= w_step[g][4*F-1:3*F];
                r_rad[g] <= w_step[g][2*F-1:0];
            end
        end
    end

    assign o_ctrl = r_ctrl[N_ST-1];
    assign o_root = r_root[N_ST-1];

endmodule

// ===== src/rft_falloff.sv =====
// Hermite falloff 1 - 3d^2 + 2d^3 and byte scaling, three register stages.
// Needs rft_pkg for the control struct and the output width.
module rft_falloff import rft_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [FRAC_BITS-1:0] i_root,
    output logic                 o_valid,
    output logic [OUT_W-1:0]     o_intensity
);

    localparam int F = FRAC_BITS;
    localparam logic [F:0]   ONE       = {1'b1, {F{1'b0}}};
    localparam logic [F+1:0] THREE_ONE = {2'b11, {F{1'b0}}};

    logic [2:0]       r_valid;
    logic [F:0]       r_d2;
    logic [F+1:0]     r_t;
    logic [F:0]       r_h;
    logic [OUT_W-1:0] r_out;

    logic [F:0]       w_d;
    logic [2*F+1:0]   w_dd;
    logic [2*F+2:0]   w_pt;
    logic [F+2:0]     w_p;
    logic [F:0]       n_h;
    logic [F+8:0]     w_hs;

    // Stage 1: clamp the distance, square it, form 3 - 2d
    assign w_d  = i_ctrl.clamp ? ONE : {1'b0, i_root};
    assign w_dd = (2*F+2)'(w_d) * (2*F+2)'(w_d);

    // Stage 2: p = d^2 * (3 - 2d), saturate, h = 1 - p
    assign w_pt = (2*F+3)'(r_d2) * (2*F+3)'(r_t);
    assign w_p  = w_pt[2*F+2:F];
    assign n_h  = (w_p > (F+3)'(ONE)) ? '0 : ONE - w_p[F:0];

    // Stage 3: scale by full-scale byte and truncate
    assign w_hs = (F+9)'(r_h) * (F+9)'(OUT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_ctrl.valid};
        end
        r_d2  <= w_dd[2*F:F];
        r_t   <= THREE_ONE - {w_d, 1'b0};
        r_h   <= n_h;
        r_out <= w_hs[F+OUT_W-1:F];
    end

    assign o_valid     = r_valid[2];
    assign o_intensity = r_out;

endmodule

// ===== src/radial_falloff_texel.sv =====
// Top level of the radial falloff texel generator: front end and pipeline.
// Needs rft_pkg, rft_div, rft_sqrt and rft_falloff.
//
// One texel word (i_col, i_row) is taken on every clock at which start is high
// and busy is low; busy is high only while reset is held, so the block takes a
// word per cycle without pause. Each word gives one o_intensity byte, marked by
// o_valid for one cycle. The pipeline is made of three front stages that form the
// squared offset from the centre, the pipelined long divider (four quotient bits
// per stage), the pipelined square root (four root bits per stage) and three back
// stages that evaluate the Hermite polynomial. Results cannot be held off, so the
// receiver must take every o_valid cycle. Write the map size only while no texel
// is in flight; a size of zero acts as one.
module radial_falloff_texel import rft_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_intensity
);

    localparam int A_W   = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
    localparam int SQ_W  = 2 * A_W;
    localparam int NUM_W = SQ_W + 1;
    localparam int S2_W  = 2 * CFG_W;
    localparam int N_DIV = (2 * FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int N_SQ  = (FRAC_BITS + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int LATENCY = 3 + N_DIV + N_SQ + 3;
    localparam logic [S2_W-1:0] S2_RESET = S2_W'(MAP_SIZE_RESET) * S2_W'(MAP_SIZE_RESET);

    logic                 w_accept;
    logic [CFG_W-1:0]     r_map_size;
    logic [S2_W-1:0]      r_s2;
    logic [CFG_W-1:0]     w_size;
    logic [S2_W-1:0]      n_s2;
    logic [A_W-1:0]       w_size_ext;
    logic [A_W-1:0]       w_two_col;
    logic [A_W-1:0]       w_two_row;
    logic [A_W-1:0]       n_a;
    logic [A_W-1:0]       n_b;
    logic [NUM_W-1:0]     n_num;

    logic                 r_v1;
    logic                 r_v2;
    logic [A_W-1:0]       r_a;
    logic [A_W-1:0]       r_b;
    logic [SQ_W-1:0]      r_sqa;
    logic [SQ_W-1:0]      r_sqb;
    t_ctrl                r_ctrl3;
    logic [S2_W-1:0]      r_num;

    t_ctrl                w_div_ctrl;
    logic [2*FRAC_BITS-1:0] w_quo;
    t_ctrl                w_sq_ctrl;
    logic [FRAC_BITS-1:0] w_root;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // Hold the map size and its square
    assign w_size = (r_map_size == '0) ? CFG_W'(1) : r_map_size;
    assign n_s2   = S2_W'(w_size) * S2_W'(w_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= MAP_SIZE_RESET;
            r_s2       <= S2_RESET;
        end else begin
            if (i_cfg_we) begin
                r_map_size <= i_cfg_data;
            end
            r_s2 <= n_s2;
        end
    end

    // Stage 1: offsets |2x - size| from the centre
    assign w_size_ext = A_W'(w_size);
    assign w_two_col  = A_W'({i_col, 1'b0});
    assign w_two_row  = A_W'({i_row, 1'b0});
    assign n_a = (w_two_col >= w_size_ext) ? w_two_col - w_size_ext : w_size_ext - w_two_col;
    assign n_b = (w_two_row >= w_size_ext) ? w_two_row - w_size_ext : w_size_ext - w_two_row;

    // Stage 3: sum of squares, clamp test against size squared
    assign n_num = NUM_W'(r_sqa) + NUM_W'(r_sqb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ctrl3 <= '0;
        end else begin
            r_v1          <= w_accept;
            r_v2          <= r_v1;
            r_ctrl3.valid <= r_v2;
            r_ctrl3.clamp <= (n_num >= NUM_W'(r_s2));
        end
        r_a   <= n_a;
        r_b   <= n_b;
        // Stage 2: square each offset
        r_sqa <= SQ_W'(r_a) * SQ_W'(r_a);
        r_sqb <= SQ_W'(r_b) * SQ_W'(r_b);
        r_num <= n_num[S2_W-1:0];
    end

    // Squared distance as a fraction with 2*FRAC_BITS bits
    rft_div #(
        .FRAC_BITS (FRAC_BITS),
        .DEN_W     (S2_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl3),
        .i_num   (r_num),
        .i_den   (r_s2),
        .o_ctrl  (w_div_ctrl),
        .o_quo   (w_quo)
    );

    // Distance with FRAC_BITS fraction bits
    rft_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .i_rad   (w_quo),
        .o_ctrl  (w_sq_ctrl),
        .o_root  (w_root)
    );

    // Falloff polynomial and byte output
    rft_falloff #(
        .FRAC_BITS (FRAC_BITS)
    ) u_falloff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_sq_ctrl),
        .i_root      (w_root),
        .o_valid     (o_valid),
        .o_intensity (o_intensity)
    );

    // Every taken word comes out after the fixed latency, and nothing else does
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(w_accept, LATENCY))
        else $error("result strobe does not match accepted words");

    // A texel at or beyond the unit circle gives zero
    a_clamp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl3.valid && r_ctrl3.clamp) |-> ##(LATENCY - 3) (o_valid && o_intensity == '0))
        else $error("clamped texel did not give zero intensity");

    // The exact centre gives full scale
    a_centre_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_two_col == w_size_ext && w_two_row == w_size_ext)
        |-> ##LATENCY (o_valid && o_intensity == OUT_MAX))
        else $error("centre texel did not give full intensity");

endmodule
